>>> design/mbc_pkg.sv
// Shared types and constants for the mail body canonicalizer.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package mbc_pkg;

  // Input item codes carried on the slave-side tuser.
  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_EOL  = 2'd1,
    FUNC_EOB  = 2'd2
  } func_e;

  // Result kinds carried on the master-side tuser.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CRLF = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  localparam int CrlfCntW = 16;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;

  // Register indexes of the configuration port.
  localparam logic RegBodyRelaxed = 1'b0;

  // Queue between front and back.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  // One decoded item: the results it causes, in emission order
  // crlf run, space, byte, end marker.
  typedef struct packed {
    logic                crlf_en;
    logic [CrlfCntW-1:0] crlf_cnt;
    logic                space_en;
    logic                byte_en;
    logic [7:0]          data_byte;
    logic                end_en;
  } cmd_t;

endpackage

>>> design/mbc_front.sv
// Front end: accepts body items, tracks line state and the blank-line
// counter, and emits one command word per item that causes results. Uses mbc_pkg.
`timescale 1ns / 1ps

module mbc_front import mbc_pkg::*; #(
  parameter int BLANK_COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       relaxed_i,
  input  logic       accept_i,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int CntW = (BLANK_COUNT_BITS < CrlfCntW) ? BLANK_COUNT_BITS : CrlfCntW;
  localparam logic [CntW-1:0] CntCap = {CntW{1'b1}};

  logic [CntW-1:0] blank_cnt_q, blank_cnt_d;
  logic            pend_space_q, pend_space_d;
  logic            line_q, line_d;
  logic            seen_q, seen_d;
  cmd_t            cmd;

  always_comb begin
    blank_cnt_d  = blank_cnt_q;
    pend_space_d = pend_space_q;
    line_d       = line_q;
    seen_d       = seen_q;
    cmd          = '0;
    case (func_e'(func_i))
      FUNC_BYTE: begin
        if (relaxed_i && (data_byte_i == CharSpace || data_byte_i == CharTab)) begin
          pend_space_d = 1'b1;
        end else begin
          if (!line_q) begin
            // release held-back empty lines ahead of the first byte
            cmd.crlf_en  = (blank_cnt_q != '0);
            cmd.crlf_cnt = CrlfCntW'(blank_cnt_q);
            blank_cnt_d  = '0;
            line_d       = 1'b1;
            seen_d       = 1'b1;
          end
          cmd.space_en  = pend_space_q;
          pend_space_d  = 1'b0;
          cmd.byte_en   = 1'b1;
          cmd.data_byte = data_byte_i;
        end
      end
      FUNC_EOL: begin
        if (line_q) begin
          cmd.crlf_en  = 1'b1;
          cmd.crlf_cnt = CrlfCntW'(1);
        end else if (blank_cnt_q != CntCap) begin
          blank_cnt_d = blank_cnt_q + CntW'(1);
        end
        line_d       = 1'b0;
        pend_space_d = 1'b0;
      end
      FUNC_EOB: begin
        cmd.crlf_en  = line_q || (!relaxed_i && !seen_q);
        cmd.crlf_cnt = CrlfCntW'(1);
        cmd.end_en   = 1'b1;
        blank_cnt_d  = '0;
        pend_space_d = 1'b0;
        line_d       = 1'b0;
        seen_d       = 1'b0;
      end
      default: begin
        // unused code: drop
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_cnt_q  <= '0;
      pend_space_q <= 1'b0;
      line_q       <= 1'b0;
      seen_q       <= 1'b0;
    end else if (accept_i) begin
      blank_cnt_q  <= blank_cnt_d;
      pend_space_q <= pend_space_d;
      line_q       <= line_d;
      seen_q       <= seen_d;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && (cmd.crlf_en || cmd.space_en || cmd.byte_en || cmd.end_en);

endmodule

>>> design/mbc_fifo.sv
// Short command queue between front and back ends.
// Holds cmd_t words from mbc_pkg in a small register array.
`timescale 1ns / 1ps

module mbc_fifo import mbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t rdata_o
);

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + FifoCntW'(1)))
    else $error("command queue count lost a push");

endmodule

>>> design/mbc_back.sv
// Back end: walks the queue head's results, one word a cycle unless the
// receiver stalls, into a registered master-side output. Uses mbc_pkg.
`timescale 1ns / 1ps

module mbc_back import mbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  cmd_t                head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  // bit 0 crlf run, bit 1 space, bit 2 byte, bit 3 end marker
  logic [3:0] sent_q, sent_d;
  logic [3:0] pend, pick, rest;
  logic       load;

  logic                valid_q, valid_d;
  kind_e               kind_q, kind_d;
  logic [7:0]          byte_q, byte_d;
  logic [CrlfCntW-1:0] cnt_q, cnt_d;
  logic                last_q, last_d;

  assign pend = {head_i.end_en, head_i.byte_en, head_i.space_en, head_i.crlf_en} & ~sent_q;
  assign pick = pend & (~pend + 4'd1);
  assign rest = pend & ~pick;
  assign load = head_valid_i && (!valid_q || m_axis_tready);
  assign pop_o = load && (rest == '0);

  always_comb begin
    sent_d  = sent_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = (rest == '0);
      sent_d  = (rest == '0) ? 4'd0 : (sent_q | pick);
      byte_d  = '0;
      cnt_d   = '0;
      case (pick)
        4'b0001: begin
          kind_d = KIND_CRLF;
          cnt_d  = head_i.crlf_cnt;
        end
        4'b0010: begin
          kind_d = KIND_DATA;
          byte_d = CharSpace;
        end
        4'b0100: begin
          kind_d = KIND_DATA;
          byte_d = head_i.data_byte;
        end
        default: begin
          kind_d = KIND_END;
        end
      endcase
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      sent_q  <= sent_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {cnt_q, byte_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_END) |-> last_q)
    else $error("end marker not flagged last");

  a_crlf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((kind_q == KIND_CRLF) == (cnt_q != '0)))
    else $error("crlf count does not match kind");

  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (sent_q == '0))
    else $error("progress mask kept after pop");

endmodule

>>> design/mail_body_canonicalizer_core.sv
// Mail body canonicalizer (simple and relaxed body canonicalization).
// Uses mbc_pkg; instantiates mbc_front, mbc_fifo and mbc_back.
//
// Slave stream: s_axis_tuser carries the item code (byte, end of line, end of
// body), s_axis_tdata the body byte. Master stream: one word per result,
// m_axis_tuser the kind (data byte, CRLF run, end marker), m_axis_tdata the
// byte and CRLF count, m_axis_tlast marking the final result of an input item.
// APB port: register 0 at address 0, bit 0 selects relaxed mode; write it
// only while the block is idle.
// Throughput: one input item per cycle while the queue has room, when each
// causes at most one result (the usual body byte); an item causing two or
// three results sends them one by one through the single output register.
// An accepted item's command is queued, then registered in the output stage.
// A four-entry command queue sits between the front and the output stage, so
// input keeps flowing while the receiver stalls until the queue fills; then
// s_axis_tready drops. Reset clears line state, blank-line count, the queue
// and the output stage, and sets simple mode.
`timescale 1ns / 1ps

module mail_body_canonicalizer_core import mbc_pkg::*; #(
  parameter int BLANK_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] crlf_count
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic relaxed_q;
  logic accept, push, pop, full, head_valid;
  cmd_t cmd, head;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relaxed_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegBodyRelaxed) begin
      relaxed_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegBodyRelaxed) ? {31'd0, relaxed_q} : 32'd0;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mbc_front #(
    .BLANK_COUNT_BITS(BLANK_COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .relaxed_i  (relaxed_q),
    .accept_i   (accept),
    .func_i     (s_axis_tuser),
    .data_byte_i(s_axis_tdata),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  mbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .rdata_o(head)
  );

  mbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> tb/sv/mail_body_canonicalizer_checker.sv
// Scoreboard for the mail body canonicalizer: tracks the relaxed-mode
// register, predicts the canonical words of each accepted input word and
// compares them with the master stream. Depends on mbc_pkg.
`timescale 1ns / 1ps

module mail_body_canonicalizer_checker import mbc_pkg::*; #(
  parameter int BLANK_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] crlf_count
  input  logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          out_byte;
    logic [CrlfCntW-1:0] crlf_count;
    logic                last;
  } canon_word_t;

  localparam int unsigned BlankCap =
      (BLANK_COUNT_BITS >= 16) ? 32'hFFFF : (32'd1 << BLANK_COUNT_BITS) - 32'd1;
  localparam logic [2:0] RelaxedAddr = {RegBodyRelaxed, 2'b00};

  bit          relaxed_mode;
  int unsigned held_blanks;
  bit          space_owed;
  bit          line_has_text;
  bit          body_has_text;
  canon_word_t canon_words_due[$];
  int          mismatches;

  function automatic canon_word_t make_word(kind_e k, logic [7:0] b, logic [CrlfCntW-1:0] n);
    canon_word_t w;
    w.kind       = k;
    w.out_byte   = b;
    w.crlf_count = n;
    w.last       = 1'b0;
    return w;
  endfunction

  // Advance the body state by one input word and queue the words it yields.
  function automatic void canonicalize_word(input logic [1:0] code, input logic [7:0] b);
    canon_word_t produced[$];
    case (code)
      FUNC_BYTE: begin
        if (relaxed_mode && (b == CharSpace || b == CharTab)) begin
          space_owed = 1'b1;
        end else begin
          if (!line_has_text) begin
            // release held-back empty lines ahead of this line's text
            if (held_blanks != 0)
              produced.push_back(make_word(KIND_CRLF, 8'h00, CrlfCntW'(held_blanks)));
            held_blanks   = 0;
            line_has_text = 1'b1;
            body_has_text = 1'b1;
          end
          if (space_owed) produced.push_back(make_word(KIND_DATA, CharSpace, '0));
          space_owed = 1'b0;
          produced.push_back(make_word(KIND_DATA, b, '0));
        end
      end
      FUNC_EOL: begin
        if (line_has_text) produced.push_back(make_word(KIND_CRLF, 8'h00, CrlfCntW'(1)));
        else if (held_blanks < BlankCap) held_blanks++;
        line_has_text = 1'b0;
        space_owed    = 1'b0;
      end
      FUNC_EOB: begin
        if (line_has_text || (!relaxed_mode && !body_has_text))
          produced.push_back(make_word(KIND_CRLF, 8'h00, CrlfCntW'(1)));
        produced.push_back(make_word(KIND_END, 8'h00, '0));
        held_blanks   = 0;
        space_owed    = 1'b0;
        line_has_text = 1'b0;
        body_has_text = 1'b0;
      end
      default: ;
    endcase
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) canon_words_due.push_back(produced[i]);
  endfunction

  function automatic void note_mismatch(string what, canon_word_t want, canon_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: want kind %0d byte %02h crlf %0d last %0b, %s",
               $realtime, what, want.kind, want.out_byte, want.crlf_count, want.last,
               $sformatf("got kind %0d byte %02h crlf %0d last %0b",
                         got.kind, got.out_byte, got.crlf_count, got.last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    canon_word_t got;
    canon_word_t want;
    if (!rst_ni) begin
      relaxed_mode  = 1'b0;
      held_blanks   = 0;
      space_owed    = 1'b0;
      line_has_text = 1'b0;
      body_has_text = 1'b0;
      canon_words_due.delete();
      mismatches    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RelaxedAddr)
        relaxed_mode = pwdata[0];
      if (s_axis_tvalid && s_axis_tready) canonicalize_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = kind_e'(m_axis_tuser);
        got.out_byte   = m_axis_tdata[7:0];
        got.crlf_count = m_axis_tdata[23:8];
        got.last       = m_axis_tlast;
        if (canon_words_due.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = canon_words_due.pop_front();
          if (got !== want) note_mismatch("word mismatch", want, got);
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= canon_words_due.size();
  end

endmodule

>>> tb/sv/mail_body_canonicalizer_core_tb.sv
// Top of the mail body canonicalizer bench: clock, reset, stream and register
// stimulus, and the verdict. Depends on mbc_pkg, the core and the checker.
`timescale 1ns / 1ps

module mail_body_canonicalizer_core_tb;
  import mbc_pkg::*;

  localparam logic [1:0] FuncUnused  = 2'd3;
  localparam logic [2:0] RelaxedAddr = {RegBodyRelaxed, 2'b00};
  localparam int         StallLimit  = 2000;
  localparam int         RandomWords = 180;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          stall_cycles = 0;
  int unsigned words_sent = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  mail_body_canonicalizer_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mail_body_canonicalizer_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Receiver: random back-pressure while rx_idle, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle && $urandom_range(0, 99) < 34);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      stall_cycles++;
    else
      stall_cycles = 0;
    if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one word; return at the falling edge after it is taken.
  task automatic send_word(input logic [1:0] code, input logic [7:0] b);
    while (tx_idle && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (code != FuncUnused) words_sent++;
  endtask

  // Hold the sender until every predicted word is out, then let the pipe settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_relaxed(input bit mode);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RelaxedAddr;
    pwdata  <= {31'($urandom), mode};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CharSpace;
    if (r < 28) return CharTab;
    if (r < 40) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // One body of random lines; some lines empty, the last one maybe left open.
  task automatic send_body(input int min_lines, input int max_lines, input int max_len);
    int nlines;
    int len;
    nlines = $urandom_range(min_lines, max_lines);
    for (int l = 0; l < nlines; l++) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 49) == 0) send_word(FuncUnused, 8'($urandom));
          send_word(FUNC_BYTE, pick_body_byte());
        end
      end
      if (l != nlines - 1 || $urandom_range(0, 1) != 0) send_word(FUNC_EOL, 8'($urandom));
      if ($urandom_range(0, 39) == 0) drain_results();
    end
    send_word(FUNC_EOB, 8'($urandom));
  endtask

  initial begin
    int body_idx;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // simple mode: empty body, byte extremes, held blank lines, open last line
    write_relaxed(1'b0);
    send_word(FUNC_EOB, 8'h5a);
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'hff);
    send_word(FUNC_BYTE, CharSpace);
    send_word(FUNC_BYTE, CharTab);
    send_word(FUNC_BYTE, 8'h41);
    send_word(FUNC_EOL, 8'hff);
    send_word(FUNC_EOL, 8'h00);
    send_word(FUNC_EOL, 8'ha5);
    send_word(FUNC_BYTE, 8'h62);
    send_word(FUNC_EOB, 8'hff);

    // relaxed mode: empty body, leading and trailing whitespace,
    // whitespace-only line, unused code
    write_relaxed(1'b1);
    send_word(FUNC_EOB, 8'h00);
    send_word(FUNC_BYTE, CharSpace);
    send_word(FUNC_BYTE, CharTab);
    send_word(FUNC_BYTE, 8'h78);
    send_word(FUNC_BYTE, CharSpace);
    send_word(FUNC_BYTE, CharTab);
    send_word(FUNC_EOL, 8'h3c);
    send_word(FUNC_BYTE, CharTab);
    send_word(FUNC_BYTE, CharSpace);
    send_word(FUNC_EOL, 8'hc3);
    send_word(FuncUnused, 8'h79);
    send_word(FUNC_BYTE, 8'h79);
    send_word(FUNC_EOB, 8'h00);

    body_idx = 0;
    while (words_sent < 24 + RandomWords) begin
      if (body_idx > 0 && $urandom_range(0, 3) == 0) write_relaxed(1'($urandom_range(0, 1)));
      tx_idle = !(body_idx inside {[6:10]});
      rx_idle = tx_idle;
      if (body_idx == 3) begin
        // stall the receiver while the sender streams a long body
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        send_body(4, 6, 12);
      end else begin
        send_body(0, 5, 8);
      end
      body_idx++;
    end

    // hold a long run of blank lines, then release it
    write_relaxed(1'b0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (16) send_word(FUNC_EOL, 8'($urandom));
    send_word(FUNC_BYTE, 8'h5a);
    send_word(FUNC_EOL, 8'($urandom));
    send_word(FUNC_EOB, 8'($urandom));

    drain_results();
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
